// ----- hw/rtl/ssd_pkg.sv -----
`default_nettype none

package ssd_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned CountW    = $clog2(WordBits + 1);
  localparam int unsigned ValueW    = 16;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned DotW      = 8;
  localparam int unsigned ClampW    = 10;
  localparam int unsigned RemW      = 7;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned BarIdxW   = 4;
  localparam int unsigned DotIdxW   = 2;
  localparam int unsigned HalfW     = 16;

  localparam logic [ValueW-1:0]  ValueMax = 16'd999;
  localparam logic [LevelW-1:0]  BarMax   = 8'd8;
  localparam logic [DotW-1:0]    DotMax   = 8'd3;

  localparam logic       OpDisplay = 1'b0;
  localparam logic       OpRaw     = 1'b1;

  typedef logic [WordBits-1:0] word_t;

  // digit patterns for the outer positions, PCDE--------GFAB
  localparam logic [HalfW-1:0] OuterDigit [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };

  // digit patterns for the middle position, bits 11..4
  localparam logic [HalfW-1:0] MiddleDigit [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };

  localparam word_t BarPattern [9] = '{
    32'h00000000, 32'h01000000, 32'h03000000, 32'h07000000, 32'h0F000000,
    32'h0F800000, 32'h0FC00000, 32'h0FE00000, 32'h0FF00000
  };

  localparam word_t DotPattern [4] = '{
    32'h00000000, 32'h80000000, 32'h00000800, 32'h00008000
  };

endpackage

`default_nettype wire

// ----- hw/rtl/ssd_req_if.sv -----
`default_nettype none

interface ssd_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [ssd_pkg::ValueW-1:0]     display_value;
  logic [ssd_pkg::LevelW-1:0]     bar_level;
  logic [ssd_pkg::DotW-1:0]       dot_select;
  logic [ssd_pkg::WordBits-1:0]   raw_word;

  modport source (
    output valid, operation, display_value, bar_level, dot_select, raw_word,
    input  ready
  );
  modport sink (
    input  valid, operation, display_value, bar_level, dot_select, raw_word,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/ssd_ser_if.sv -----
`default_nettype none

interface ssd_ser_if;
  logic valid;
  logic ready;
  logic serial_data;
  logic last;

  modport source (output valid, serial_data, last, input ready);
  modport sink (input valid, serial_data, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ssd_encoder.sv -----
`default_nettype none

module ssd_encoder (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  ssd_req_if.sink                req_i,
  output logic                   word_valid_o,
  output ssd_pkg::word_t         word_o,
  input  wire                    word_ready_i
);

  // stage 1: clamp and hundreds split
  logic                                s1_valid_q;
  logic                                s1_op_q;
  ssd_pkg::word_t                      s1_raw_q;
  logic [ssd_pkg::BarIdxW-1:0]         s1_bar_q;
  logic [ssd_pkg::DotIdxW-1:0]         s1_dot_q;
  logic [ssd_pkg::DigitW-1:0]          s1_hund_q;
  logic [ssd_pkg::RemW-1:0]            s1_rem_q;

  // stage 2: finished word
  logic                                s2_valid_q;
  ssd_pkg::word_t                      s2_word_q;

  logic                                s1_adv;
  logic                                s2_adv;
  logic                                in_take;

  logic [ssd_pkg::ClampW-1:0]          value_c;
  logic [ssd_pkg::HalfW-1:0]           prod_h;
  logic [ssd_pkg::DigitW-1:0]          hund_d;
  logic [ssd_pkg::ClampW-1:0]          rem_full;
  logic [ssd_pkg::BarIdxW-1:0]         bar_d;
  logic [ssd_pkg::DotIdxW-1:0]         dot_d;

  logic [14:0]                         prod_t;
  logic [ssd_pkg::DigitW-1:0]          tens;
  logic [ssd_pkg::RemW-1:0]            ones_full;
  logic [ssd_pkg::DigitW-1:0]          ones;
  ssd_pkg::word_t                      word_d;

  assign s2_adv      = !s2_valid_q || word_ready_i;
  assign s1_adv      = !s1_valid_q || s2_adv;
  assign req_i.ready = s1_adv;
  assign in_take     = req_i.valid && s1_adv;

  always_comb begin
    value_c  = (req_i.display_value > ssd_pkg::ValueMax) ?
               ssd_pkg::ValueMax[ssd_pkg::ClampW-1:0] :
               req_i.display_value[ssd_pkg::ClampW-1:0];
    // value / 100 as (value * 41) >> 12, exact below 1000
    prod_h   = {6'd0, value_c} * 16'd41;
    hund_d   = prod_h[15:12];
    rem_full = value_c - ({2'd0, hund_d, 4'd0} * 10'd0 + {hund_d, 6'd0}
               + {1'd0, hund_d, 5'd0} + {4'd0, hund_d, 2'd0});
    bar_d    = (req_i.bar_level > ssd_pkg::BarMax) ?
               ssd_pkg::BarMax[ssd_pkg::BarIdxW-1:0] :
               req_i.bar_level[ssd_pkg::BarIdxW-1:0];
    dot_d    = (req_i.dot_select > ssd_pkg::DotMax) ? '0 :
               req_i.dot_select[ssd_pkg::DotIdxW-1:0];
  end

  always_comb begin
    // rem / 10 as (rem * 205) >> 11, exact below 100
    prod_t    = {8'd0, s1_rem_q} * 15'd205;
    tens      = prod_t[14:11];
    ones_full = s1_rem_q - ({tens, 3'd0} + {2'd0, tens, 1'd0});
    ones      = ones_full[ssd_pkg::DigitW-1:0];
    if (s1_op_q == ssd_pkg::OpRaw) begin
      word_d = s1_raw_q;
    end else begin
      word_d = {ssd_pkg::OuterDigit[s1_hund_q], 16'd0}
             | {16'd0, ssd_pkg::MiddleDigit[tens]}
             | {16'd0, ssd_pkg::OuterDigit[ones]}
             | ssd_pkg::BarPattern[s1_bar_q]
             | ssd_pkg::DotPattern[s1_dot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= req_i.operation;
      s1_raw_q  <= req_i.raw_word;
      s1_bar_q  <= bar_d;
      s1_dot_q  <= dot_d;
      s1_hund_q <= hund_d;
      s1_rem_q  <= rem_full[ssd_pkg::RemW-1:0];
    end
    if (s2_adv && s1_valid_q) begin
      s2_word_q <= word_d;
    end
  end

  assign word_valid_o = s2_valid_q;
  assign word_o       = s2_word_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ssd_cell.sv -----
`default_nettype none

module ssd_cell (
  input  wire  clk_i,
  input  wire  load_i,
  input  wire  shift_i,
  input  wire  load_bit_i,
  input  wire  next_bit_i,
  output logic data_o
);

  logic data_q;
  logic data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_bit_i;
    end else if (shift_i) begin
      data_d = next_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/seven_segment_serial_display_driver_unit.sv -----
// channel  | dir | fields                                                   | handshake
// req_i    | in  | operation, display_value, bar_level, dot_select, raw_word | valid/ready
// ser_o    | out | serial_data, last                                        | valid/ready
//
// each request yields 32 serial bits, lsb first, one per ready cycle; last marks bit 31.
// requests are paced by the 32-cell shift chain, which holds and shifts out one word at a time.
// a request passes stage 1 (clamp/split) and stage 2 (encode) before it enters the chain.
// two requests wait in the encoder while the chain shifts; a stall on ser_o freezes the chain.
// asynchronous active-low reset clears all valid and count state.
`default_nettype none

module seven_segment_serial_display_driver_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  ssd_req_if.sink    req_i,
  ssd_ser_if.source  ser_o
);

  logic                          word_valid;
  ssd_pkg::word_t                word;
  logic                          word_ready;

  logic [ssd_pkg::CountW-1:0]    count_q;
  logic [ssd_pkg::CountW-1:0]    count_d;
  logic                          load;
  logic                          shift;
  logic [ssd_pkg::WordBits-1:0]  chain;

  ssd_encoder u_encoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .word_valid_o (word_valid),
    .word_o       (word),
    .word_ready_i (word_ready)
  );

  assign shift      = ser_o.valid && ser_o.ready;
  assign word_ready = (count_q == '0) || ((count_q == ssd_pkg::CountW'(1)) && ser_o.ready);
  assign load       = word_valid && word_ready;

  for (genvar i = 0; i < ssd_pkg::WordBits; i++) begin : g_cell
    logic next_bit;
    if (i == ssd_pkg::WordBits - 1) begin : g_end
      assign next_bit = 1'b0;
    end else begin : g_mid
      assign next_bit = chain[i+1];
    end
    ssd_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load),
      .shift_i    (shift),
      .load_bit_i (word[i]),
      .next_bit_i (next_bit),
      .data_o     (chain[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (load) begin
      count_d = ssd_pkg::CountW'(ssd_pkg::WordBits);
    end else if (shift) begin
      count_d = count_q - ssd_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ser_o.valid       = (count_q != '0);
  assign ser_o.serial_data = chain[0];
  assign ser_o.last        = (count_q == ssd_pkg::CountW'(1));

endmodule

`default_nettype wire

// ----- hw/rtl/ssd_checker.sv -----
`default_nettype none

module ssd_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire req_valid_i,
  input wire req_ready_i,
  input wire ser_valid_i,
  input wire ser_ready_i,
  input wire ser_data_i,
  input wire ser_last_i
);

  // a held bit keeps its value
  a_ser_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_i && !ser_ready_i |=>
      ser_valid_i && $stable(ser_data_i) && $stable(ser_last_i))
    else $error("serial bit changed while stalled");

  // a word keeps flowing until its last bit
  a_word_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_i && ser_ready_i && !ser_last_i |=> ser_valid_i)
    else $error("word broke off before last bit");

  // requests back up only behind a busy chain
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> ser_valid_i)
    else $error("request stalled with idle output");

  // last never marks two consecutive serial bits
  a_last_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_valid_i && ser_ready_i && ser_last_i |=> !(ser_valid_i && ser_last_i))
    else $error("last repeated on consecutive bits");

endmodule

bind seven_segment_serial_display_driver_unit ssd_checker u_ssd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .ser_valid_i (ser_o.valid),
  .ser_ready_i (ser_o.ready),
  .ser_data_i  (ser_o.serial_data),
  .ser_last_i  (ser_o.last)
);

`default_nettype wire

// ----- verif/ssd_word_checker.sv -----
`timescale 1ns / 1ps

module ssd_word_checker (
  input  wire  clk_i,
  input  wire  rst_ni,
  ssd_req_if   req,
  ssd_ser_if   ser,
  output int   mismatch_count_o,
  output int   pending_bits_o
);

  typedef struct packed {
    logic serial_data;
    logic last;
  } ser_bit_t;

  // segment codes, PCDE--------GFAB for the outer digits
  localparam logic [ssd_pkg::HalfW-1:0] SegOuter [10] = '{
    16'h7007, 16'h4001, 16'h300B, 16'h600B, 16'h400D,
    16'h600E, 16'h700E, 16'h4003, 16'h700F, 16'h600F
  };
  localparam logic [ssd_pkg::HalfW-1:0] SegMiddle [10] = '{
    16'h0770, 16'h0410, 16'h03B0, 16'h06B0, 16'h04D0,
    16'h06E0, 16'h07E0, 16'h0430, 16'h07F0, 16'h06F0
  };

  ser_bit_t       expected_bits [$];
  ser_bit_t       head_bit;
  ssd_pkg::word_t next_word;

  initial begin
    mismatch_count_o = 0;
    pending_bits_o   = 0;
  end

  function automatic ssd_pkg::word_t compose_segment_word(
    logic                       op,
    logic [ssd_pkg::ValueW-1:0] value,
    logic [ssd_pkg::LevelW-1:0] level,
    logic [ssd_pkg::DotW-1:0]   dot,
    ssd_pkg::word_t             raw
  );
    int unsigned    shown;
    int unsigned    lit;
    ssd_pkg::word_t w;
    if (op == ssd_pkg::OpRaw) return raw;
    shown = (value > ssd_pkg::ValueMax) ? int'(ssd_pkg::ValueMax) : int'(value);
    lit   = (level > ssd_pkg::BarMax) ? int'(ssd_pkg::BarMax) : int'(level);
    w = {SegOuter[shown / 100], 16'h0000};
    w |= {16'h0000, SegMiddle[(shown / 10) % 10]};
    w |= {16'h0000, SegOuter[shown % 10]};
    // bargraph climbs 24..27, then 23 down to 20
    for (int i = 0; i < lit; i++) begin
      if (i < 4) w[24 + i] = 1'b1;
      else w[27 - i] = 1'b1;
    end
    case (dot)
      8'd1: w[31] = 1'b1;
      8'd2: w[11] = 1'b1;
      8'd3: w[15] = 1'b1;
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bits.delete();
      pending_bits_o = 0;
    end else begin
      if (ser.valid && ser.ready) begin
        if (expected_bits.size() == 0) begin
          $error("serial bit with no request pending: serial_data %0b last %0b",
                 ser.serial_data, ser.last);
          mismatch_count_o++;
        end else begin
          head_bit = expected_bits.pop_front();
          if (ser.serial_data !== head_bit.serial_data) begin
            $error("serial_data expected %0b actual %0b",
                   head_bit.serial_data, ser.serial_data);
            mismatch_count_o++;
          end
          if (ser.last !== head_bit.last) begin
            $error("last expected %0b actual %0b", head_bit.last, ser.last);
            mismatch_count_o++;
          end
        end
      end
      if (req.valid && req.ready) begin
        next_word = compose_segment_word(req.operation, req.display_value,
                                         req.bar_level, req.dot_select, req.raw_word);
        for (int k = 0; k < ssd_pkg::WordBits; k++) begin
          expected_bits.push_back('{serial_data: next_word[k],
                                    last: (k == ssd_pkg::WordBits - 1)});
        end
      end
      pending_bits_o = expected_bits.size();
    end
  end

endmodule

// ----- verif/tb_seven_segment_serial_display_driver_unit.sv -----
`timescale 1ns / 1ps

module tb_seven_segment_serial_display_driver_unit;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 67;
  int unsigned cycle_count = 0;
  int          mismatch_count;
  int          pending_bits;

  ssd_req_if req_if();
  ssd_ser_if ser_if();

  seven_segment_serial_display_driver_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .ser_o  (ser_if)
  );

  ssd_word_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req              (req_if),
    .ser              (ser_if),
    .mismatch_count_o (mismatch_count),
    .pending_bits_o   (pending_bits)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    ser_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      ser_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(
    logic                       op,
    logic [ssd_pkg::ValueW-1:0] value,
    logic [ssd_pkg::LevelW-1:0] level,
    logic [ssd_pkg::DotW-1:0]   dot,
    ssd_pkg::word_t             raw
  );
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid         = 1'b1;
    req_if.operation     = op;
    req_if.display_value = value;
    req_if.bar_level     = level;
    req_if.dot_select    = dot;
    req_if.raw_word      = raw;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random_request();
    logic                       op;
    logic [ssd_pkg::ValueW-1:0] value;
    logic [ssd_pkg::LevelW-1:0] level;
    logic [ssd_pkg::DotW-1:0]   dot;
    op    = ($urandom_range(99) < 15) ? ssd_pkg::OpRaw : ssd_pkg::OpDisplay;
    value = ($urandom_range(3) == 0) ? ssd_pkg::ValueW'($urandom_range(65535))
                                     : ssd_pkg::ValueW'($urandom_range(999));
    level = ($urandom_range(3) == 0) ? ssd_pkg::LevelW'($urandom_range(255))
                                     : ssd_pkg::LevelW'($urandom_range(10));
    dot   = ($urandom_range(3) == 0) ? ssd_pkg::DotW'($urandom_range(255))
                                     : ssd_pkg::DotW'($urandom_range(5));
    send_request(op, value, level, dot, $urandom);
  endtask

  task automatic drain_results();
    req_if.valid = 1'b0;
    wait (pending_bits == 0);
    @(negedge clk_i);
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.operation     = ssd_pkg::OpDisplay;
    req_if.display_value = '0;
    req_if.bar_level     = '0;
    req_if.dot_select    = '0;
    req_if.raw_word      = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes, clamps, every dot code, raw words
    send_request(ssd_pkg::OpDisplay, 16'd0, 8'd0, 8'd0, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd999, 8'd8, 8'd1, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd1000, 8'd9, 8'd2, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'hFFFF, 8'hFF, 8'd3, 32'hFFFFFFFF);
    send_request(ssd_pkg::OpDisplay, 16'd888, 8'd4, 8'd4, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd123, 8'd1, 8'hFF, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd456, 8'd5, 8'd0, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd789, 8'd7, 8'd2, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd7, 8'd2, 8'd3, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd80, 8'd3, 8'd1, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd90, 8'd6, 8'd128, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd1024, 8'd128, 8'd2, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd8, 8'd8, 8'd3, 32'h0);
    send_request(ssd_pkg::OpDisplay, 16'd65, 8'd0, 8'd1, 32'h0);
    send_request(ssd_pkg::OpRaw, 16'd0, 8'd0, 8'd0, 32'h00000000);
    send_request(ssd_pkg::OpRaw, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF);
    send_request(ssd_pkg::OpRaw, 16'd555, 8'd3, 8'd1, 32'hA5A5A5A5);
    send_request(ssd_pkg::OpRaw, 16'd0, 8'd0, 8'd0, 32'h00000001);
    send_request(ssd_pkg::OpRaw, 16'd0, 8'd0, 8'd0, 32'h80000000);
    send_request(ssd_pkg::OpRaw, 16'd0, 8'd0, 8'd0, 32'h5A5A5A5A);
    drain_results();

    repeat (PhaseItems) send_random_request();
    send_idle_pct = 67;
    recv_idle_pct = 17;
    repeat (PhaseItems) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PhaseItems) send_random_request();
    drain_results();
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0 && pending_bits == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
